### rtl/core/alad_pkg.sv
package alad_pkg;

  localparam int SAMPLE_W = 32;
  localparam int LIM_W    = 32;
  localparam int DB_W     = 31;
  localparam int EN_W     = 4;
  localparam int NUM_LIM  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIFF_W   = ((SAMPLE_W > LIM_W) ? SAMPLE_W : LIM_W) + 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] LIM_HH = 2'd0;
  localparam logic [1:0] LIM_H  = 2'd1;
  localparam logic [1:0] LIM_L  = 2'd2;
  localparam logic [1:0] LIM_LL = 2'd3;

  localparam logic EV_CLEAR = 1'b0;
  localparam logic EV_RAISE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LIM_HH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_H   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_L   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIM_LL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_QGATE   = 3'd6;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                bad_qual;
  } in_item_t;

  typedef struct packed {
    logic       event_kind;
    logic [1:0] limit_index;
    logic       last_event;
  } out_item_t;

  typedef struct packed {
    logic [NUM_LIM-1:0][LIM_W-1:0] lim;
    logic [DB_W-1:0]               deadband;
    logic [EN_W-1:0]               enable;
    logic                          qgate;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] index;
  } ev_t;

  typedef struct packed {
    ev_t [NUM_LIM-1:0] ev;
    logic [1:0]        last_idx;
  } entry_t;

  function automatic ev_t ev_make(input logic kind, input logic [1:0] index);
    ev_t e;
    e.kind  = kind;
    e.index = index;
    return e;
  endfunction

endpackage

### rtl/core/alad_front.sv
module alad_front
  import alad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output logic     push,
  output entry_t   push_data,
  input  logic     q_full
);

  logic               b_v_r;
  logic [NUM_LIM-1:0] up_r;
  logic [NUM_LIM-1:0] dn_r;
  logic               gate_r;
  logic [NUM_LIM-1:0] act_r;

  logic [NUM_LIM-1:0] up_nxt;
  logic [NUM_LIM-1:0] dn_nxt;
  logic [NUM_LIM-1:0] act_nxt;
  logic [NUM_LIM-1:0] clr;
  logic [NUM_LIM-1:0] rse;
  logic [NUM_LIM-1:0] en;
  ev_t [NUM_LIM-1:0]  ev;
  logic [2:0]         n;
  logic               need_push;
  logic               b_go;
  logic               accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    logic signed [DIFF_W-1:0] s_ext;
    logic signed [DIFF_W-1:0] db_pos;
    logic signed [DIFF_W-1:0] db_neg;
    logic signed [DIFF_W-1:0] diff;
    s_ext  = DIFF_W'($signed(in_data.sample));
    db_pos = $signed(DIFF_W'(cfg.deadband));
    db_neg = -db_pos;
    for (int i = 0; i < NUM_LIM; i++) begin
      diff      = s_ext - DIFF_W'($signed(cfg.lim[i]));
      up_nxt[i] = diff > db_pos;
      dn_nxt[i] = diff < db_neg;
    end
  end

  assign en  = cfg.enable;
  assign clr = {up_r[LIM_LL], up_r[LIM_L], dn_r[LIM_H], dn_r[LIM_HH]};
  assign rse = {dn_r[LIM_LL], dn_r[LIM_L], up_r[LIM_H], up_r[LIM_HH]};

  always_comb begin
    logic hit;
    act_nxt = act_r;
    ev      = '0;
    n       = 3'd0;
    hit     = 1'b0;
    if (gate_r) begin
      act_nxt = '0;
    end else begin
      if (en[LIM_HH] && act_nxt[LIM_HH] && clr[LIM_HH]) begin
        act_nxt[LIM_HH] = 1'b0;
        ev[n[1:0]] = ev_make(EV_CLEAR, LIM_HH);
        n = n + 3'd1;
        hit = 1'b1;
      end else if (en[LIM_H] && act_nxt[LIM_H] && clr[LIM_H]) begin
        act_nxt[LIM_H] = 1'b0;
        ev[n[1:0]] = ev_make(EV_CLEAR, LIM_H);
        n = n + 3'd1;
        hit = 1'b1;
      end
      if (!hit) begin
        if (en[LIM_LL] && act_nxt[LIM_LL] && clr[LIM_LL]) begin
          act_nxt[LIM_LL] = 1'b0;
          ev[n[1:0]] = ev_make(EV_CLEAR, LIM_LL);
          n = n + 3'd1;
        end
        if (en[LIM_L] && act_nxt[LIM_L] && clr[LIM_L]) begin
          act_nxt[LIM_L] = 1'b0;
          ev[n[1:0]] = ev_make(EV_CLEAR, LIM_L);
          n = n + 3'd1;
        end
      end
      hit = 1'b0;
      if (en[LIM_HH] && !act_nxt[LIM_HH] && rse[LIM_HH]) begin
        act_nxt[LIM_HH] = 1'b1;
        ev[n[1:0]] = ev_make(EV_RAISE, LIM_HH);
        n = n + 3'd1;
        hit = 1'b1;
      end else if (en[LIM_H] && !act_nxt[LIM_H] && rse[LIM_H]) begin
        act_nxt[LIM_H] = 1'b1;
        ev[n[1:0]] = ev_make(EV_RAISE, LIM_H);
        n = n + 3'd1;
        hit = 1'b1;
      end
      if (!hit) begin
        if (en[LIM_LL] && !act_nxt[LIM_LL] && rse[LIM_LL]) begin
          act_nxt[LIM_LL] = 1'b1;
          ev[n[1:0]] = ev_make(EV_RAISE, LIM_LL);
          n = n + 3'd1;
        end
        if (en[LIM_L] && !act_nxt[LIM_L] && rse[LIM_L]) begin
          act_nxt[LIM_L] = 1'b1;
          ev[n[1:0]] = ev_make(EV_RAISE, LIM_L);
          n = n + 3'd1;
        end
      end
    end
  end

  assign need_push = b_v_r && (n != 3'd0);
  assign b_go      = !need_push || !q_full;
  assign in_stall  = b_v_r && !b_go;
  assign push      = need_push && !q_full;

  assign push_data.ev       = ev;
  assign push_data.last_idx = n[1:0] - 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      act_r <= '0;
    end else begin
      if (b_v_r && b_go) begin
        act_r <= act_nxt;
      end
      if (accept) begin
        b_v_r <= 1'b1;
      end else if (b_go) begin
        b_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      up_r   <= up_nxt;
      dn_r   <= dn_nxt;
      gate_r <= cfg.qgate && in_data.bad_qual;
    end
  end

endmodule

### rtl/core/alad_fifo.sv
module alad_fifo
  import alad_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  entry_t wr_data,
  output logic   full,
  input  logic   rd_en,
  output entry_t rd_data,
  output logic   empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full    = cnt_r == CNT_W'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/alad_back.sv
module alad_back
  import alad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  entry_t    q_data,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  entry_t     cur_r;
  logic       cur_v_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_data_r;

  logic slot_free;
  logic load;
  logic is_last;

  assign slot_free = !out_valid_r || !out_stall;
  assign load      = slot_free && cur_v_r;
  assign is_last   = idx_r == cur_r.last_idx;
  assign pop       = !q_empty && (!cur_v_r || (load && is_last));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_v_r <= 1'b1;
        idx_r   <= '0;
      end else if (load && is_last) begin
        cur_v_r <= 1'b0;
      end else if (load) begin
        idx_r <= idx_r + 2'd1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (slot_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_data;
    end
    if (load) begin
      out_data_r.event_kind  <= cur_r.ev[idx_r].kind;
      out_data_r.limit_index <= cur_r.ev[idx_r].index;
      out_data_r.last_event  <= is_last;
    end
  end

endmodule

### rtl/core/analog_limit_alarm_deadband.sv
// Analog limit alarm with deadband: each input transfer carries one signed Q16.16 sample
// and a quality flag; the block tracks four alarm bits (high-high, high, low, low-low) and
// sends one result transfer per alarm raised or cleared, at most four per sample, the final
// one marked with last_event. A sample is compared against all limits in the cycle it is
// taken, its events are resolved against the alarm state from the registered compare
// results and queued, and the output stage sends one event per cycle unless out_stall
// holds it. A new sample can be taken every cycle unless a held sample's events meet a
// full two-entry event queue, which decouples the compare side from the output register.
// Configuration writes are always ready and must be issued only while the block is idle.
module analog_limit_alarm_deadband
  import alad_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  logic   push;
  entry_t push_data;
  logic   q_full;
  logic   q_empty;
  entry_t q_data;
  logic   pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LIM_HH:   cfg_r.lim[LIM_HH] <= cfg_data[LIM_W-1:0];
        CFG_LIM_H:    cfg_r.lim[LIM_H]  <= cfg_data[LIM_W-1:0];
        CFG_LIM_L:    cfg_r.lim[LIM_L]  <= cfg_data[LIM_W-1:0];
        CFG_LIM_LL:   cfg_r.lim[LIM_LL] <= cfg_data[LIM_W-1:0];
        CFG_DEADBAND: cfg_r.deadband    <= cfg_data[DB_W-1:0];
        CFG_ENABLE:   cfg_r.enable      <= cfg_data[EN_W-1:0];
        CFG_QGATE:    cfg_r.qgate       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  alad_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  alad_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_data),
    .full    (q_full),
    .rd_en   (pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  alad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/core/alad_checker.sv
module alad_checker
  import alad_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_event |=> out_valid)
    else $error("gap inside one sample's events");

  a_raise_then_raise: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_event && out_data.event_kind == EV_RAISE
    |=> out_data.event_kind == EV_RAISE)
    else $error("clear event after raise within one sample");

endmodule

bind analog_limit_alarm_deadband alad_checker u_alad_checker (.*);
